// ===== hw/rtl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

    // Block and key geometry
    localparam int WORD_W      = 32;
    localparam int BLOCK_W     = 2 * WORD_W;
    localparam int KEY_WORDS   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CMD_W       = 1;

    // Default round count (one round = two half-rounds)
    localparam int ROUNDS_DEFAULT = 32;

    // Golden-ratio constant of the key schedule
    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    // Key register addresses on the config port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_WORD0 = 2'd0,
        CFG_KEY_WORD1 = 2'd1,
        CFG_KEY_WORD2 = 2'd2,
        CFG_KEY_WORD3 = 2'd3
    } cfg_index_t;

    // Operation carried in tuser
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Feistel mix: ((v << 4) ^ (v >> 5)) + v
    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
        mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xtea_block_cipher.sv =====
`default_nettype none

// XTEA block cipher, 64-bit block, 128-bit key held in four config words.
// Every accepted transaction carries one block and a command bit (tuser) that
// selects encryption or decryption; it yields exactly one result transaction.
// The rounds are unrolled into 2*ROUNDS register stages, one Feistel
// half-round per stage, behind an input register, so a new block is accepted
// every clock cycle while s_tready is high, and results leave in input order. A
// two-entry output buffer decouples the pipeline from m_tready:
// s_tready is a registered signal that drops only while both entries hold
// results that have not been taken. The key must be written only while no
// block is in flight; the key words reset to zero.
module xtea_block_cipher #(
    parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Config write port
    input  wire logic                              cfg_wen,
    input  wire logic [xtea_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]       cfg_wdata,

    // Input stream
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [xtea_pkg::BLOCK_W-1:0]      s_tdata,   // [31:0] word_first, [63:32] word_second
    input  wire logic [xtea_pkg::CMD_W-1:0]        s_tuser,   // [0] cmd

    // Result stream
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [xtea_pkg::BLOCK_W-1:0]      m_tdata    // [31:0] result_first, [63:32] result_second
);
    import xtea_pkg::*;

    localparam int STAGES = 2 * ROUNDS;

    // Key registers
    logic [WORD_W-1:0] key_reg [0:KEY_WORDS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_wen) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY_WORD0: key_reg[0] <= cfg_wdata;
                CFG_KEY_WORD1: key_reg[1] <= cfg_wdata;
                CFG_KEY_WORD2: key_reg[2] <= cfg_wdata;
                CFG_KEY_WORD3: key_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline registers; stage 0 is the input register
    logic              valid_reg [0:STAGES];
    logic              cmd_reg   [0:STAGES];
    logic [WORD_W-1:0] v0_reg    [0:STAGES];
    logic [WORD_W-1:0] v1_reg    [0:STAGES];

    // Output buffer state
    logic [1:0]         cnt_reg, cnt_next;
    logic [BLOCK_W-1:0] ent_reg [0:1];
    logic               ready_reg, ready_next;

    logic pipe_en;
    logic push, pop;

    assign pipe_en  = ready_reg;
    assign s_tready = ready_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            valid_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cmd_reg[0] <= s_tuser[0];
            v0_reg[0]  <= s_tdata[WORD_W-1:0];
            v1_reg[0]  <= s_tdata[BLOCK_W-1:WORD_W];
        end
    end

    // One half-round per stage; round sums are elaboration-time constants
    for (genvar h = 0; h < STAGES; h++) begin : g_half
        localparam logic [WORD_W-1:0] ENC_SUM =
            WORD_W'(64'((h + 1) / 2) * 64'(XTEA_DELTA));
        localparam logic [WORD_W-1:0] DEC_SUM =
            WORD_W'(64'(ROUNDS - (h + 1) / 2) * 64'(XTEA_DELTA));
        localparam bit IS_EVEN = ((h % 2) == 0);
        localparam logic [1:0] ENC_KI = IS_EVEN ? ENC_SUM[1:0]   : ENC_SUM[12:11];
        localparam logic [1:0] DEC_KI = IS_EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

        logic              dec;
        logic              upd_v0;
        logic [WORD_W-1:0] keyed, src, dst, fval, dst_new;
        logic [WORD_W-1:0] v0_next, v1_next;

        always_comb begin
            dec    = (cmd_reg[h] == CMD_DECRYPT);
            // even stage: encrypt updates v0, decrypt updates v1; odd swaps
            upd_v0 = IS_EVEN ? !dec : dec;
            keyed  = dec ? (DEC_SUM + key_reg[DEC_KI]) : (ENC_SUM + key_reg[ENC_KI]);
            src    = upd_v0 ? v1_reg[h] : v0_reg[h];
            dst    = upd_v0 ? v0_reg[h] : v1_reg[h];
            fval   = mix(src) ^ keyed;
            dst_new = dec ? (dst - fval) : (dst + fval);
            v0_next = upd_v0 ? dst_new : v0_reg[h];
            v1_next = upd_v0 ? v1_reg[h] : dst_new;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[h+1] <= 1'b0;
            end else if (pipe_en) begin
                valid_reg[h+1] <= valid_reg[h];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                cmd_reg[h+1] <= cmd_reg[h];
                v0_reg[h+1]  <= v0_next;
                v1_reg[h+1]  <= v1_next;
            end
        end
    end

    // Two-entry output buffer; entry 0 is the head
    assign push = pipe_en && valid_reg[STAGES];
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
        ready_next = (cnt_next != 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 2'd0;
            ready_reg <= 1'b1;
        end else begin
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            // shift forward, or take the new result straight into the head
            if (cnt_reg == 2'd2) begin
                ent_reg[0] <= ent_reg[1];
            end else if (push) begin
                ent_reg[0] <= {v1_reg[STAGES], v0_reg[STAGES]};
            end
            if (push && cnt_reg == 2'd2) begin
                ent_reg[1] <= {v1_reg[STAGES], v0_reg[STAGES]};
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                ent_reg[0] <= {v1_reg[STAGES], v0_reg[STAGES]};
            end else begin
                ent_reg[1] <= {v1_reg[STAGES], v0_reg[STAGES]};
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = ent_reg[0];

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_checker.sv =====
`default_nettype none

module xtea_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [xtea_pkg::BLOCK_W-1:0]      m_tdata
);
    import xtea_pkg::*;

    // Reset empties the output side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input side only backs up while results are waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A full buffer that is not drained stays full
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && !m_tready) |=> !s_tready)
        else $error("input ready rose without a result transaction");

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or vanished");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (.*);

`default_nettype wire

// ===== test/xtea_block_cipher_tb.sv =====
`default_nettype none

module xtea_block_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xtea_pkg::*;

    localparam int  TB_ROUNDS      = ROUNDS_DEFAULT;
    localparam int  PIPE_LATENCY   = 2 * TB_ROUNDS + 1;
    localparam int  MAX_GAP        = 12;
    localparam int  RANDOM_PHASES  = 5;
    localparam int  PHASE_ITEMS    = 260;
    localparam int  STALL_ITEMS    = 200;
    localparam int  STALL_CYCLES   = 400;
    localparam real RUN_LIMIT_NS   = 2_000_000.0;

    typedef struct packed {
        logic [WORD_W-1:0] result_second;
        logic [WORD_W-1:0] result_first;
    } cipher_block_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BLOCK_W-1:0]     s_tdata;   // [31:0] word_first, [63:32] word_second
    logic [CMD_W-1:0]       s_tuser;   // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready;
    logic [BLOCK_W-1:0]     m_tdata;   // [31:0] result_first, [63:32] result_second

    // Key copy used for prediction; only changed while the pipeline is empty
    logic [WORD_W-1:0] key_shadow [KEY_WORDS];

    cipher_block_t expected_blocks [$];
    int            error_count;
    bit            no_idle;
    int            rx_hold_cycles;

    xtea_block_cipher #(
        .ROUNDS(TB_ROUNDS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Feistel round function
    function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] v);
        round_mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Full XTEA transform of one block under the shadow key
    function automatic cipher_block_t xtea_transform(input logic cmd,
                                                     input logic [WORD_W-1:0] w0,
                                                     input logic [WORD_W-1:0] w1);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
        cipher_block_t     res;
        v0 = w0;
        v1 = w1;
        if (cmd == CMD_ENCRYPT) begin
            sum = '0;
            for (int n = 0; n < TB_ROUNDS; n++) begin
                v0  = v0 + (round_mix(v1) ^ (sum + key_shadow[sum[1:0]]));
                sum = sum + XTEA_DELTA;
                v1  = v1 + (round_mix(v0) ^ (sum + key_shadow[sum[12:11]]));
            end
        end else begin
            // decryption runs the schedule backwards from ROUNDS*delta
            sum = 32'(TB_ROUNDS) * XTEA_DELTA;
            for (int n = 0; n < TB_ROUNDS; n++) begin
                v1  = v1 - (round_mix(v0) ^ (sum + key_shadow[sum[12:11]]));
                sum = sum - XTEA_DELTA;
                v0  = v0 - (round_mix(v1) ^ (sum + key_shadow[sum[1:0]]));
            end
        end
        res.result_first  = v0;
        res.result_second = v1;
        return res;
    endfunction

    // Result checker: compare every result transaction with the oldest prediction
    always @(posedge aclk) begin
        cipher_block_t exp_blk;
        cipher_block_t got_blk;
        if (aresetn && m_tvalid && m_tready) begin
            got_blk = m_tdata;
            if (expected_blocks.size() == 0) begin
                $error("result transaction with no block in flight: %h", m_tdata);
                error_count++;
            end else begin
                exp_blk = expected_blocks.pop_front();
                if (got_blk.result_first !== exp_blk.result_first) begin
                    $error("result_first mismatch: expected %h, actual %h",
                           exp_blk.result_first, got_blk.result_first);
                    error_count++;
                end
                if (got_blk.result_second !== exp_blk.result_second) begin
                    $error("result_second mismatch: expected %h, actual %h",
                           exp_blk.result_second, got_blk.result_second);
                    error_count++;
                end
            end
        end
    end

    // Result receiver: random ready gaps, plus an optional long hold-off
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Send one block; entered and left at a falling edge
    task automatic send_block(input logic cmd, input logic [WORD_W-1:0] w0,
                              input logic [WORD_W-1:0] w1);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w1, w0};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_blocks.push_back(xtea_transform(cmd, w0, w1));
        @(negedge aclk);
    endtask

    // Stop sending and wait until every block has come back
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(negedge aclk);
    endtask

    task automatic write_key_reg(input cfg_index_t idx, input logic [WORD_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        key_shadow[idx] = value;
    endtask

    // Load all four key words; pipeline must be empty
    task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                            input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        drain_pipeline();
        write_key_reg(CFG_KEY_WORD0, k0);
        write_key_reg(CFG_KEY_WORD1, k1);
        write_key_reg(CFG_KEY_WORD2, k2);
        write_key_reg(CFG_KEY_WORD3, k3);
        cfg_wen <= 1'b0;
    endtask

    // Encrypt a block, then decrypt its ciphertext back
    task automatic send_round_trip(input logic [WORD_W-1:0] p0, input logic [WORD_W-1:0] p1);
        cipher_block_t ct;
        ct = xtea_transform(CMD_ENCRYPT, p0, p1);
        send_block(CMD_ENCRYPT, p0, p1);
        send_block(CMD_DECRYPT, ct.result_first, ct.result_second);
    endtask

    // Extreme words, both commands, reset key and extreme keys
    task automatic test_directed_vectors();
        // key after reset is all zero
        send_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_round_trip(32'h0123_4567, 32'h89AB_CDEF);

        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);

        // distinct words so a swapped key index shows up
        load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        send_block(CMD_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
        send_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        send_round_trip(32'hFFFF_FFFF, 32'h0000_0000);
        send_round_trip(32'h0000_0000, 32'hFFFF_FFFF);

        load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_round_trip(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // Random blocks under a new key per phase; some phases run back to back
    task automatic test_random_traffic();
        int                sent;
        int                sel;
        logic [WORD_W-1:0] edge_words [4];
        edge_words[0] = 32'h0000_0000;
        edge_words[1] = 32'hFFFF_FFFF;
        edge_words[2] = 32'h8000_0000;
        edge_words[3] = 32'h0000_0001;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 2) begin
                load_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
            end else begin
                load_key($urandom, $urandom, $urandom, $urandom);
            end
            no_idle = (phase % 2 == 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sel = $urandom_range(0, 9);
                if (sel < 3) begin
                    send_round_trip($urandom, $urandom);
                    sent += 2;
                end else if (sel == 3) begin
                    send_block(1'($urandom_range(0, 1)),
                               edge_words[2'($urandom_range(0, 3))],
                               edge_words[2'($urandom_range(0, 3))]);
                    sent++;
                end else begin
                    send_block(1'($urandom_range(0, 1)), $urandom, $urandom);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver holds off while blocks keep coming, so the input must stall
    task automatic test_input_stall();
        load_key($urandom, $urandom, $urandom, $urandom);
        rx_hold_cycles = STALL_CYCLES;
        no_idle = 1'b1;
        for (int i = 0; i < STALL_ITEMS; i++) begin
            send_block(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
        no_idle = 1'b0;
    endtask

    // Main sequence
    initial begin
        error_count    = 0;
        no_idle        = 1'b0;
        rx_hold_cycles = 0;
        for (int i = 0; i < KEY_WORDS; i++) key_shadow[i] = '0;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = CFG_KEY_WORD0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_ENCRYPT;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_vectors();
        test_random_traffic();
        test_input_stall();

        drain_pipeline();
        // catch any stray result after the last expected one
        repeat (PIPE_LATENCY + 8) @(negedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
